// File: rtl/psfp_pkg.sv
// ============================================================================
// psfp_pkg
// Shared constants and types for the particle sensor frame parser.
// ============================================================================
package psfp_pkg;

    localparam int PSFP_FRAME_BYTES = 32;   // default frame length in bytes
    localparam int BYTE_W           = 8;
    localparam int SUM_W            = 16;
    localparam int WIDX_W           = 4;
    localparam int WVAL_W           = 16;
    localparam int OUT_TDATA_W      = 24;   // 4 + 16 + 1 bits, padded to 3 bytes

    localparam int FIRST_CAP_POS    = 4;    // first payload byte in the frame
    localparam int LAST_SUM_POS     = 29;   // last byte covered by the checksum
    localparam int CAP_BYTES        = LAST_SUM_POS - FIRST_CAP_POS + 1;
    localparam int CAP_IDX_W        = $clog2(CAP_BYTES);
    localparam int POS_CMP_W        = 7;    // holds any position up to 64
    localparam int MEAS_WORDS       = 12;
    localparam int WORD_COUNT       = 14;
    localparam int QUEUE_DEPTH      = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH       = 2'd2;

    localparam logic [BYTE_W-1:0] RST_START_FIRST  = 8'd66;
    localparam logic [BYTE_W-1:0] RST_START_SECOND = 8'd77;
    localparam logic [BYTE_W-1:0] RST_LENGTH       = 8'd28;

    typedef struct packed {
        logic [BYTE_W-1:0] start_first;
        logic [BYTE_W-1:0] start_second;
        logic [BYTE_W-1:0] length;
    } t_cfg;

    // One finished frame: checksum verdict plus payload bytes 4..29
    typedef struct packed {
        logic                              ok;
        logic [CAP_BYTES-1:0][BYTE_W-1:0]  bytes;
    } t_frame_rec;

    typedef struct packed {
        logic              last;
        logic              ok;
        logic [WVAL_W-1:0] value;
        logic [WIDX_W-1:0] index;
    } t_result;

endpackage

// File: rtl/psfp_front.sv
// ============================================================================
// psfp_front
// Byte tracker: header check, running sum, payload capture, checksum verdict.
// ============================================================================
module psfp_front #(
    parameter int FRAME_BYTES = psfp_pkg::PSFP_FRAME_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  psfp_pkg::t_cfg              i_cfg,
    input  logic                        i_valid,
    input  logic [psfp_pkg::BYTE_W-1:0] i_byte,
    output logic                        o_ready,
    input  logic                        i_queue_full,
    output logic                        o_push,
    output psfp_pkg::t_frame_rec        o_rec
);
    import psfp_pkg::*;

    localparam int POS_W = $clog2(FRAME_BYTES);

    logic [POS_W-1:0]                  r_pos, n_pos;
    logic [SUM_W-1:0]                  r_sum, n_sum;
    logic [BYTE_W-1:0]                 r_chk_hi;
    logic [CAP_BYTES-1:0][BYTE_W-1:0]  r_cap, n_cap;

    logic [POS_CMP_W-1:0] pos_x;
    logic                 accept, at_last, hdr_bad, sum_en;
    logic [SUM_W-1:0]     sum_base, chk;

    assign pos_x   = POS_CMP_W'(r_pos);
    assign at_last = (pos_x == POS_CMP_W'(FRAME_BYTES - 1));
    // the final byte of a frame always pushes, so hold it while the queue is full
    assign o_ready = !(i_queue_full && at_last);
    assign accept  = i_valid && o_ready;

    always_comb begin
        hdr_bad = ((pos_x == POS_CMP_W'(0)) && (i_byte != i_cfg.start_first))  ||
                  ((pos_x == POS_CMP_W'(1)) && (i_byte != i_cfg.start_second)) ||
                  ((pos_x == POS_CMP_W'(2)) && (i_byte != '0))                  ||
                  ((pos_x == POS_CMP_W'(3)) && (i_byte != i_cfg.length));
        sum_en   = (pos_x <= POS_CMP_W'(LAST_SUM_POS)) &&
                   (pos_x <  POS_CMP_W'(FRAME_BYTES - 2));
        sum_base = (pos_x == '0) ? '0 : r_sum;
        if (hdr_bad || at_last) begin
            n_sum = '0;
            n_pos = '0;
        end else begin
            n_sum = sum_en ? sum_base + SUM_W'(i_byte) : sum_base;
            n_pos = r_pos + POS_W'(1);
        end
        for (int j = 0; j < CAP_BYTES; j++) begin
            n_cap[j] = (pos_x == POS_CMP_W'(j + FIRST_CAP_POS)) ? i_byte : r_cap[j];
        end
    end

    assign chk          = {r_chk_hi, i_byte};
    assign o_push       = accept && at_last;
    assign o_rec.ok     = (chk == r_sum);
    assign o_rec.bytes  = n_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sum <= '0;
        end else if (accept) begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cap <= n_cap;
            if (pos_x == POS_CMP_W'(FRAME_BYTES - 2)) begin
                r_chk_hi <= i_byte;
            end
        end
    end

endmodule

// File: rtl/psfp_queue.sv
// ============================================================================
// psfp_queue
// Short queue of finished frame records between front and back.
// ============================================================================
module psfp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  psfp_pkg::t_frame_rec i_rec,
    output logic                 o_full,
    output logic                 o_valid,
    output psfp_pkg::t_frame_rec o_rec,
    input  logic                 i_pop
);
    import psfp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_frame_rec             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]       r_wr, r_rd;
    logic [CNT_W-1:0]       r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !(i_pop && o_valid)) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop && o_valid) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop && o_valid) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

endmodule

// File: rtl/psfp_back.sv
// ============================================================================
// psfp_back
// Word sequencer: walks one frame record into results behind an output register.
// ============================================================================
module psfp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  psfp_pkg::t_frame_rec i_rec,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output psfp_pkg::t_result    o_result
);
    import psfp_pkg::*;

    logic [WIDX_W-1:0]    r_k, n_k;
    logic                 r_valid;
    t_result              r_result, n_result;
    logic                 load, last_k;
    logic [CAP_IDX_W-1:0] idx_hi, idx_lo, idx_sb;

    assign load   = i_valid && (!r_valid || i_ready);
    assign last_k = (r_k == WIDX_W'(WORD_COUNT - 1));

    always_comb begin
        idx_hi = CAP_IDX_W'({r_k, 1'b0});
        idx_lo = idx_hi + CAP_IDX_W'(1);
        idx_sb = CAP_IDX_W'(r_k) + CAP_IDX_W'(MEAS_WORDS);
        if (!i_rec.ok) begin
            // bad checksum: one flagged result and drop the record
            n_result = '{last: 1'b1, ok: 1'b0, value: '0, index: '0};
            o_pop    = load;
            n_k      = '0;
        end else begin
            n_result.index = r_k;
            n_result.ok    = 1'b1;
            n_result.last  = last_k;
            if (r_k < WIDX_W'(MEAS_WORDS)) begin
                n_result.value = {i_rec.bytes[idx_hi], i_rec.bytes[idx_lo]};
            end else begin
                n_result.value = {{(WVAL_W - BYTE_W){1'b0}}, i_rec.bytes[idx_sb]};
            end
            o_pop = load && last_k;
            n_k   = last_k ? '0 : r_k + WIDX_W'(1);
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_k     <= n_k;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= n_result;
        end
    end

endmodule

// File: rtl/particle_sensor_frame_parser.sv
// ============================================================================
// particle_sensor_frame_parser
// Parses fixed-length particle sensor frames into measurement words.
// ============================================================================
//  channel    | dir | handshake                        | payload
//  s_axis     | in  | i_s_axis_tvalid / o_s_axis_tready | tdata[7:0] rx_byte
//  m_axis     | out | o_m_axis_tvalid / i_m_axis_tready | tdata word_index, word_value,
//             |     |                                   | frame_ok; tlast last_word
//  cfg        | in  | i_cfg_we                          | i_cfg_addr, i_cfg_wdata
//
//  One byte is taken per cycle; the final byte of a frame stalls only while both
//  queue entries hold frames. Results leave one per cycle from an output register
//  while tready is high. A good frame yields 14 results, a bad one a single result.
//  Reset (synchronous) returns to hunting, empties the queue, restores registers.
// ============================================================================
module particle_sensor_frame_parser #(
    parameter int FRAME_BYTES = psfp_pkg::PSFP_FRAME_BYTES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,  // [7:0] rx_byte
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [3:0] word_index, [19:4] word_value, [20] frame_ok, [23:21] zero
    output logic [psfp_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                              o_m_axis_tlast,  // last_word
    input  logic                              i_cfg_we,
    input  logic [psfp_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [psfp_pkg::BYTE_W-1:0]       i_cfg_wdata
);
    import psfp_pkg::*;

    t_cfg       r_cfg;
    logic       q_push, q_full, q_valid, q_pop;
    t_frame_rec push_rec, head_rec;
    t_result    result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_first  <= RST_START_FIRST;
            r_cfg.start_second <= RST_START_SECOND;
            r_cfg.length       <= RST_LENGTH;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_START_FIRST:  r_cfg.start_first  <= i_cfg_wdata;
                CFG_START_SECOND: r_cfg.start_second <= i_cfg_wdata;
                CFG_LENGTH:       r_cfg.length       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    psfp_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_s_axis_tvalid),
        .i_byte       (i_s_axis_tdata),
        .o_ready      (o_s_axis_tready),
        .i_queue_full (q_full),
        .o_push       (q_push),
        .o_rec        (push_rec)
    );

    psfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rec   (head_rec),
        .i_pop   (q_pop)
    );

    psfp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_rec    (head_rec),
        .o_pop    (q_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (result)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W - WIDX_W - WVAL_W - 1){1'b0}},
                             result.ok, result.value, result.index};
    assign o_m_axis_tlast = result.last;

endmodule

// File: rtl/psfp_checker.sv
// ============================================================================
// psfp_checker
// Port-level checks on the result stream of the frame parser.
// ============================================================================
module psfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);
    localparam logic [3:0] LAST_INDEX = 4'd13;

    // nothing is offered right after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered right after reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // a failed frame is a single zeroed result that closes the frame
    a_fail_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[20] |->
            o_m_axis_tlast && (o_m_axis_tdata[19:0] == 20'd0))
        else $error("bad checksum result malformed");

    // in a good frame only word 13, the last index, closes the frame
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[20] |->
            ((o_m_axis_tdata[3:0] == LAST_INDEX) == o_m_axis_tlast))
        else $error("last flag does not match word index");

    // words of a good frame step through their indexes in order
    a_index_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tdata[20] && !o_m_axis_tlast
            ##1 o_m_axis_tvalid |->
            o_m_axis_tdata[20] && (o_m_axis_tdata[3:0] == $past(o_m_axis_tdata[3:0]) + 4'd1))
        else $error("word index out of order");

endmodule

bind particle_sensor_frame_parser psfp_checker u_psfp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// File: tb/particle_sensor_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// particle_sensor_frame_parser_tb
// Self-checking bench for the sensor frame parser. Serial bytes go in on the
// slave stream. A behavioral copy of the parser works out which words each
// byte produces. Every word that leaves the master stream is compared field
// by field with the oldest pending word. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module particle_sensor_frame_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psfp_pkg::*;

    localparam int FRAME_LEN   = PSFP_FRAME_BYTES;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // unmapped index

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [7:0]             s_tdata = '0;
    logic                   m_tready = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr = '0;
    logic [BYTE_W-1:0]      cfg_wdata = '0;
    wire                    o_s_axis_tready;
    wire                    o_m_axis_tvalid;
    wire [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    wire                    o_m_axis_tlast;

    particle_sensor_frame_parser uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),          // [7:0] rx_byte
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [3:0] index, [19:4] value, [20] ok
        .o_m_axis_tlast  (o_m_axis_tlast),   // last_word
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    // Parser mirror: header settings, frame position, checksum and bytes
    logic [7:0]  cfg_first  = RST_START_FIRST;
    logic [7:0]  cfg_second = RST_START_SECOND;
    logic [7:0]  cfg_length = RST_LENGTH;
    int          frame_pos = 0;
    logic [15:0] frame_sum = '0;
    logic [7:0]  frame_bytes [0:FRAME_LEN-1];

    t_result     expected_words [$];
    int          fail_count = 0;
    int          bytes_sent = 0;
    int          words_seen = 0;
    int          cycle_count = 0;
    bit          no_idle = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** particle_sensor_frame_parser: FAILED **");
            $finish;
        end
    end

    // Receiver: random backpressure, mostly short, occasionally long
    initial begin
        int r;
        forever begin
            @(posedge i_clk);
            r = $urandom_range(99);
            if (no_idle) begin
                m_tready <= 1'b1;
            end else if (r < 6) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(5, 20)) @(posedge i_clk);
            end else begin
                m_tready <= (r >= 30);
            end
        end
    end

    // Compare each word transaction with the oldest pending word
    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            words_seen = words_seen + 1;
            if (expected_words.size() == 0) begin
                $error("unexpected word: tdata=%h tlast=%b", o_m_axis_tdata, o_m_axis_tlast);
                fail_count = fail_count + 1;
            end else begin
                w = expected_words.pop_front();
                if (o_m_axis_tdata[3:0] !== w.index) begin
                    $error("word_index: expected %0d, got %0d", w.index, o_m_axis_tdata[3:0]);
                    fail_count = fail_count + 1;
                end
                if (o_m_axis_tdata[19:4] !== w.value) begin
                    $error("word_value: expected %h, got %h", w.value, o_m_axis_tdata[19:4]);
                    fail_count = fail_count + 1;
                end
                if (o_m_axis_tdata[20] !== w.ok) begin
                    $error("frame_ok: expected %b, got %b", w.ok, o_m_axis_tdata[20]);
                    fail_count = fail_count + 1;
                end
                if (o_m_axis_tlast !== w.last) begin
                    $error("last_word: expected %b, got %b", w.last, o_m_axis_tlast);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // Advance the mirror by one accepted byte, queue the words it releases
    task automatic predict_frame_words(input logic [7:0] b);
        int          pos;
        int          k;
        logic [15:0] chk;
        t_result     w;
        pos = frame_pos;
        if (pos >= FRAME_LEN) begin
            pos = 0;
            frame_sum = '0;
        end
        frame_bytes[pos] = b;
        if ((pos == 0 && b != cfg_first) || (pos == 1 && b != cfg_second) ||
            (pos == 2 && b != 8'h00) || (pos == 3 && b != cfg_length)) begin
            frame_pos = 0;
            frame_sum = '0;
            return;
        end
        if (pos == 0) frame_sum = '0;
        if (pos <= LAST_SUM_POS && pos + 2 < FRAME_LEN) frame_sum = frame_sum + b;
        if (pos + 1 < FRAME_LEN) begin
            frame_pos = pos + 1;
            return;
        end
        chk = {frame_bytes[FRAME_LEN-2], frame_bytes[FRAME_LEN-1]};
        if (chk != frame_sum) begin
            w = '0;
            w.last = 1'b1;
            expected_words.push_back(w);
        end else begin
            for (k = 0; k < WORD_COUNT; k++) begin
                w.index = k[WIDX_W-1:0];
                if (k < MEAS_WORDS)
                    w.value = {frame_bytes[FIRST_CAP_POS + 2*k],
                               frame_bytes[FIRST_CAP_POS + 2*k + 1]};
                else
                    w.value = {8'h00, frame_bytes[16 + k]};
                w.ok   = 1'b1;
                w.last = (k == WORD_COUNT - 1);
                expected_words.push_back(w);
            end
        end
        frame_pos = 0;
        frame_sum = '0;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_frame_words(b);
        bytes_sent = bytes_sent + 1;
    endtask

    // Hold off the sender until every pending word has left
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_START_FIRST:  cfg_first  = val;
            CFG_START_SECOND: cfg_second = val;
            CFG_LENGTH:       cfg_length = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Push the parser back to hunting for a frame start
    task automatic drain_to_hunt();
        while (frame_pos != 0) begin
            case (frame_pos)
                1:       send_byte(cfg_second ^ 8'($urandom_range(1, 255)));
                2:       send_byte(8'($urandom_range(1, 255)));
                3:       send_byte(cfg_length ^ 8'($urandom_range(1, 255)));
                default: send_byte(8'($urandom_range(255)));
            endcase
        end
    endtask

    // Whole frame; fill < 0 gives random payload, else a constant one
    task automatic send_frame(input bit good_sum, input int fill);
        logic [7:0]  fb [0:FRAME_LEN-1];
        logic [15:0] sum;
        int          i;
        fb[0] = cfg_first;
        fb[1] = cfg_second;
        fb[2] = 8'h00;
        fb[3] = cfg_length;
        for (i = FIRST_CAP_POS; i < FRAME_LEN - 2; i++)
            fb[i] = (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
        sum = '0;
        for (i = 0; i <= LAST_SUM_POS; i++) sum = sum + fb[i];
        if (!good_sum) sum = sum ^ 16'($urandom_range(1, 65535));
        fb[FRAME_LEN-2] = sum[15:8];
        fb[FRAME_LEN-1] = sum[7:0];
        for (i = 0; i < FRAME_LEN; i++) send_byte(fb[i]);
    endtask

    // Correct header up to position bad_pos, a wrong byte there
    task automatic send_broken_header(input int bad_pos);
        logic [7:0] hdr [0:3];
        int         i;
        hdr[0] = cfg_first;
        hdr[1] = cfg_second;
        hdr[2] = 8'h00;
        hdr[3] = cfg_length;
        for (i = 0; i < bad_pos; i++) send_byte(hdr[i]);
        send_byte(hdr[bad_pos] ^ 8'($urandom_range(1, 255)));
    endtask

    task automatic run_random_traffic(input int byte_goal, input int word_goal);
        int b0;
        int w0;
        int r;
        int n;
        b0 = bytes_sent;
        w0 = words_seen;
        while (bytes_sent - b0 < byte_goal || words_seen - w0 < word_goal) begin
            if ($urandom_range(9) == 0) no_idle = ($urandom_range(3) == 0);
            r = $urandom_range(99);
            if (r < 8) begin
                wait_quiet();
            end else if (r < 68) begin
                drain_to_hunt();
                send_frame($urandom_range(4) != 0, -1);
            end else if (r < 84) begin
                drain_to_hunt();
                send_broken_header($urandom_range(3));
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    case ($urandom_range(3))
                        0:       send_byte(cfg_first);
                        1:       send_byte(cfg_second);
                        default: send_byte(8'($urandom_range(255)));
                    endcase
                end
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_header_mismatch();
        int k;
        for (k = 0; k < 4; k++) send_broken_header(k);
        // A repeated start byte is discarded, not taken as a new start
        send_byte(cfg_first);
        send_byte(cfg_first);
    endtask

    task automatic test_good_frames();
        send_frame(1'b1, 8'hFF);
    endtask

    task automatic test_bad_checksum();
        send_frame(1'b0, -1);
        wait_quiet();
    endtask

    task automatic test_register_settings();
        logic [7:0] vals [0:2][0:2];
        int         p;
        vals[0] = '{8'h00, 8'hFF, 8'h00};
        vals[1] = '{8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255))};
        vals[2] = '{RST_START_FIRST, RST_START_SECOND, RST_LENGTH};
        for (p = 0; p < 3; p++) begin
            drain_to_hunt();
            wait_quiet();
            write_reg(CFG_START_FIRST,  vals[p][0]);
            write_reg(CFG_START_SECOND, vals[p][1]);
            write_reg(CFG_LENGTH,       vals[p][2]);
            write_reg(CFG_SPARE,        8'($urandom_range(255)));
            // restored defaults are exercised by the random traffic
            if (p < 2) send_frame(1'b1, (p == 0) ? 0 : -1);
        end
    endtask

    task automatic test_random_traffic();
        drain_to_hunt();
        run_random_traffic(12, 0);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_header_mismatch();
        test_good_frames();
        test_bad_checksum();
        test_register_settings();
        test_random_traffic();
        drain_to_hunt();
        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** particle_sensor_frame_parser: PASSED **");
        end else begin
            $display("** particle_sensor_frame_parser: FAILED **");
        end
        $finish;
    end

endmodule
